@@ rtl/ffa_pkg.sv @@
// Shared constants, state and status types for the first-fit allocator.
// No dependencies; used by first_fit_free_list_allocator.
package ffa_pkg;

	localparam int ARENA_BYTES     = 16384;
	localparam int MAX_FREE        = 64;
	localparam int MAX_LIVE        = 64;
	localparam int HEADER_BYTES    = 16;
	localparam int MIN_SPLIT_BYTES = 16;
	localparam int MAX_ALIGN_LOG2  = 12;

	localparam int OFF_W = 14;
	localparam int LEN_W = 15;
	localparam int PAD_W = 12;
	localparam int CNT_W = 7;
	localparam int AW    = 6;
	localparam int SEG_W = OFF_W + LEN_W;
	localparam int LIVE_W = OFF_W + LEN_W + PAD_W;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_A_SLOT,
		S_A_SCAN,
		S_F_LOOK,
		S_F_POS,
		S_F_DEC,
		S_MV,
		S_F_INS,
		S_FIN
	} state_t;

	typedef enum logic [2:0] {
		STAT_OK       = 3'd0,
		STAT_NOFIT    = 3'd1,
		STAT_FREEFULL = 3'd2,
		STAT_UNKNOWN  = 3'd3,
		STAT_LIVEFULL = 3'd4
	} status_t;

	typedef enum logic {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} cmd_t;

endpackage

@@ rtl/first_fit_free_list_allocator.sv @@
// First-fit allocator: sequencer, free segment memory and live allocation memory.
// Allocate runs slot search, then segment scan and gap close, then result;
// free runs live lookup, then position scan, shift and insert, then result.
// One command at a time: each step walks one memory entry per cycle per table.
// The receiver cannot stall: done pulses for one cycle with the result.
// Reset (and an arena_bytes write) passes through S_INIT, which rewrites segment entry zero; busy is high.
module first_fit_free_list_allocator (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic                      cmd,
	input  logic [ffa_pkg::LEN_W-1:0] size_bytes,
	input  logic [3:0]                align_log2,
	input  logic [ffa_pkg::OFF_W-1:0] free_offset,
	input  logic                      wr_en,
	input  logic [ffa_pkg::LEN_W-1:0] wr_data,
	output logic                      done,
	output logic [2:0]                status,
	output logic [ffa_pkg::OFF_W-1:0] data_offset,
	output logic [ffa_pkg::LEN_W-1:0] usage_bytes,
	output logic [ffa_pkg::CNT_W-1:0] free_segments
);

	localparam int OFF_W = ffa_pkg::OFF_W;
	localparam int LEN_W = ffa_pkg::LEN_W;
	localparam int PAD_W = ffa_pkg::PAD_W;
	localparam int CNT_W = ffa_pkg::CNT_W;
	localparam int AW    = ffa_pkg::AW;

	// tables
	logic [ffa_pkg::SEG_W-1:0]  seg_mem  [ffa_pkg::MAX_FREE];
	logic [ffa_pkg::LIVE_W-1:0] live_mem [ffa_pkg::MAX_LIVE];
	logic [ffa_pkg::SEG_W-1:0]  seg_rdata;
	logic [ffa_pkg::LIVE_W-1:0] live_rdata;
	logic                       seg_we, live_we;
	logic [AW-1:0]              seg_raddr, seg_waddr, live_waddr;
	logic [ffa_pkg::SEG_W-1:0]  seg_wdata;
	logic [ffa_pkg::LIVE_W-1:0] live_wdata;

	ffa_pkg::state_t  state_q, state_d;
	ffa_pkg::status_t st_q, st_d;
	logic [LEN_W-1:0] arena_q, arena_d, usage_q, usage_d;
	logic [CNT_W-1:0] count_q, count_d, idx_q, idx_d, p_q, p_d;
	logic [ffa_pkg::MAX_LIVE-1:0] valid_q, valid_d;
	logic [LEN_W-1:0] size_q, size_d, ksize_q, ksize_d, blen_q, blen_d;
	logic [3:0]       al_q, al_d;
	logic [OFF_W-1:0] foff_q, foff_d, bs_q, bs_d, off_q, off_d;
	logic [AW-1:0]    e_q, e_d, slot_q, slot_d, k_q, k_d;
	logic             pv_q, pv_d, mv_up_q, mv_up_d;
	logic             have_prev_q, have_prev_d, has_next_q, has_next_d;
	logic [OFF_W-1:0] prev_start_q, prev_start_d, next_start_q, next_start_d;
	logic [LEN_W-1:0] prev_len_q, prev_len_d, next_len_q, next_len_d;
	logic             done_d;
	logic [2:0]       status_d;
	logic [OFF_W-1:0] data_offset_d;
	logic [LEN_W-1:0] usage_bytes_d;
	logic [CNT_W-1:0] free_segments_d;

	// fit arithmetic
	logic [OFF_W-1:0] rd_start, lr_off;
	logic [LEN_W-1:0] rd_len, lr_size, amask, data_s, aligned, rest, wr_sat;
	logic [PAD_W-1:0] lr_pad, pad;
	logic [16:0]      total;
	logic             fit, mprev, mnext;
	logic [15:0]      prev_end, blk_end;

	assign rd_start = seg_rdata[ffa_pkg::SEG_W-1:LEN_W];
	assign rd_len   = seg_rdata[LEN_W-1:0];
	assign lr_off   = live_rdata[ffa_pkg::LIVE_W-1:LEN_W+PAD_W];
	assign lr_size  = live_rdata[LEN_W+PAD_W-1:PAD_W];
	assign lr_pad   = live_rdata[PAD_W-1:0];

	assign amask   = LEN_W'((16'd1 << al_q) - 16'd1);
	assign data_s  = LEN_W'(rd_start) + LEN_W'(ffa_pkg::HEADER_BYTES);
	assign aligned = (data_s + amask) & ~amask;
	assign pad     = PAD_W'(aligned - data_s);
	assign total   = 17'(ffa_pkg::HEADER_BYTES) + 17'(pad) + 17'(size_q);
	assign fit     = 17'(rd_len) >= total;
	assign rest    = LEN_W'(17'(rd_len) - total);

	assign prev_end = 16'(prev_start_q) + 16'(prev_len_q);
	assign blk_end  = 16'(bs_q) + 16'(blen_q);
	assign mprev    = have_prev_q && (prev_end == 16'(bs_q));
	assign mnext    = has_next_q && (blk_end == 16'(next_start_q));

	assign wr_sat = (wr_data > LEN_W'(ffa_pkg::ARENA_BYTES)) ?
		LEN_W'(ffa_pkg::ARENA_BYTES) : wr_data;

	assign busy = (state_q != ffa_pkg::S_IDLE);

	always_comb begin
		state_d = state_q;
		st_d = st_q;
		arena_d = arena_q;
		usage_d = usage_q;
		count_d = count_q;
		idx_d = idx_q;
		p_d = p_q;
		valid_d = valid_q;
		size_d = size_q;
		ksize_d = ksize_q;
		blen_d = blen_q;
		al_d = al_q;
		foff_d = foff_q;
		bs_d = bs_q;
		off_d = off_q;
		e_d = e_q;
		slot_d = slot_q;
		k_d = k_q;
		pv_d = pv_q;
		mv_up_d = mv_up_q;
		have_prev_d = have_prev_q;
		has_next_d = has_next_q;
		prev_start_d = prev_start_q;
		prev_len_d = prev_len_q;
		next_start_d = next_start_q;
		next_len_d = next_len_q;
		done_d = 1'b0;
		status_d = status;
		data_offset_d = data_offset;
		usage_bytes_d = usage_bytes;
		free_segments_d = free_segments;
		seg_we = 1'b0;
		seg_waddr = e_q;
		seg_wdata = seg_rdata;
		seg_raddr = idx_q[AW-1:0];
		live_we = 1'b0;
		live_waddr = slot_q;
		live_wdata = {aligned[OFF_W-1:0], size_q, pad};

		unique case (state_q)
			ffa_pkg::S_INIT: begin
				seg_we = 1'b1;
				seg_waddr = '0;
				seg_wdata = {{OFF_W{1'b0}}, arena_q};
				if (wr_en) begin
					// take the new size and rewrite entry zero again
					arena_d = wr_sat;
					count_d = CNT_W'(wr_sat != '0);
					valid_d = '0;
					usage_d = '0;
					state_d = ffa_pkg::S_INIT;
				end else begin
					state_d = ffa_pkg::S_IDLE;
				end
			end
			ffa_pkg::S_IDLE: begin
				if (wr_en) begin
					arena_d = wr_sat;
					count_d = CNT_W'(wr_sat != '0);
					valid_d = '0;
					usage_d = '0;
					state_d = ffa_pkg::S_INIT;
				end else if (start) begin
					size_d = size_bytes;
					al_d = (align_log2 > 4'(ffa_pkg::MAX_ALIGN_LOG2)) ?
						4'(ffa_pkg::MAX_ALIGN_LOG2) : align_log2;
					foff_d = free_offset;
					idx_d = '0;
					pv_d = 1'b0;
					off_d = '0;
					if (cmd == ffa_pkg::CMD_FREE) begin
						state_d = ffa_pkg::S_F_LOOK;
					end else if (size_bytes == '0) begin
						st_d = ffa_pkg::STAT_NOFIT;
						state_d = ffa_pkg::S_FIN;
					end else if (&valid_q) begin
						st_d = ffa_pkg::STAT_LIVEFULL;
						state_d = ffa_pkg::S_FIN;
					end else begin
						state_d = ffa_pkg::S_A_SLOT;
					end
				end
			end
			ffa_pkg::S_A_SLOT: begin
				// walk valid bits for an empty live slot
				if (!valid_q[idx_q[AW-1:0]]) begin
					slot_d = idx_q[AW-1:0];
					idx_d = '0;
					pv_d = 1'b0;
					state_d = ffa_pkg::S_A_SCAN;
				end else begin
					idx_d = idx_q + CNT_W'(1);
				end
			end
			ffa_pkg::S_A_SCAN: begin
				if (pv_q && fit) begin
					live_we = 1'b1;
					valid_d[slot_q] = 1'b1;
					usage_d = usage_q + size_q;
					st_d = ffa_pkg::STAT_OK;
					off_d = aligned[OFF_W-1:0];
					pv_d = 1'b0;
					if (rest > LEN_W'(ffa_pkg::MIN_SPLIT_BYTES)) begin
						seg_we = 1'b1;
						seg_waddr = e_q;
						seg_wdata = {OFF_W'(17'(rd_start) + total), rest};
						state_d = ffa_pkg::S_FIN;
					end else begin
						// segment consumed: close the gap
						mv_up_d = 1'b0;
						idx_d = CNT_W'(e_q) + CNT_W'(1);
						state_d = ffa_pkg::S_MV;
					end
				end else if (idx_q < count_q) begin
					pv_d = 1'b1;
					e_d = idx_q[AW-1:0];
					idx_d = idx_q + CNT_W'(1);
				end else begin
					pv_d = 1'b0;
					if (!pv_q) begin
						st_d = ffa_pkg::STAT_NOFIT;
						state_d = ffa_pkg::S_FIN;
					end
				end
			end
			ffa_pkg::S_F_LOOK: begin
				if (pv_q && valid_q[e_q] && lr_off == foff_q) begin
					k_d = e_q;
					ksize_d = lr_size;
					bs_d = foff_q - OFF_W'(ffa_pkg::HEADER_BYTES) - OFF_W'(lr_pad);
					blen_d = LEN_W'(ffa_pkg::HEADER_BYTES) + LEN_W'(lr_pad) + lr_size;
					idx_d = '0;
					pv_d = 1'b0;
					have_prev_d = 1'b0;
					state_d = ffa_pkg::S_F_POS;
				end else if (idx_q < CNT_W'(ffa_pkg::MAX_LIVE)) begin
					pv_d = 1'b1;
					e_d = idx_q[AW-1:0];
					idx_d = idx_q + CNT_W'(1);
				end else begin
					pv_d = 1'b0;
					if (!pv_q) begin
						st_d = ffa_pkg::STAT_UNKNOWN;
						state_d = ffa_pkg::S_FIN;
					end
				end
			end
			ffa_pkg::S_F_POS: begin
				if (pv_q && rd_start >= bs_q) begin
					p_d = CNT_W'(e_q);
					next_start_d = rd_start;
					next_len_d = rd_len;
					has_next_d = 1'b1;
					pv_d = 1'b0;
					state_d = ffa_pkg::S_F_DEC;
				end else begin
					if (pv_q) begin
						prev_start_d = rd_start;
						prev_len_d = rd_len;
						have_prev_d = 1'b1;
					end
					if (idx_q < count_q) begin
						pv_d = 1'b1;
						e_d = idx_q[AW-1:0];
						idx_d = idx_q + CNT_W'(1);
					end else begin
						pv_d = 1'b0;
						if (!pv_q) begin
							p_d = count_q;
							has_next_d = 1'b0;
							state_d = ffa_pkg::S_F_DEC;
						end
					end
				end
			end
			ffa_pkg::S_F_DEC: begin
				seg_waddr = AW'(p_q - CNT_W'(1));
				if (!mprev && !mnext && count_q >= CNT_W'(ffa_pkg::MAX_FREE)) begin
					st_d = ffa_pkg::STAT_FREEFULL;
					state_d = ffa_pkg::S_FIN;
				end else begin
					valid_d[k_q] = 1'b0;
					usage_d = (usage_q >= ksize_q) ? usage_q - ksize_q : '0;
					st_d = ffa_pkg::STAT_OK;
					pv_d = 1'b0;
					if (mprev && mnext) begin
						seg_we = 1'b1;
						seg_wdata = {prev_start_q, prev_len_q + blen_q + next_len_q};
						mv_up_d = 1'b0;
						idx_d = p_q + CNT_W'(1);
						state_d = ffa_pkg::S_MV;
					end else if (mprev) begin
						seg_we = 1'b1;
						seg_wdata = {prev_start_q, prev_len_q + blen_q};
						state_d = ffa_pkg::S_FIN;
					end else if (mnext) begin
						seg_we = 1'b1;
						seg_waddr = p_q[AW-1:0];
						seg_wdata = {bs_q, next_len_q + blen_q};
						state_d = ffa_pkg::S_FIN;
					end else begin
						// open a hole at p for the new segment
						mv_up_d = 1'b1;
						idx_d = count_q;
						state_d = ffa_pkg::S_MV;
					end
				end
			end
			ffa_pkg::S_MV: begin
				if (pv_q) begin
					seg_we = 1'b1;
					seg_waddr = mv_up_q ? e_q + AW'(1) : e_q - AW'(1);
					seg_wdata = seg_rdata;
				end
				if (mv_up_q) begin
					seg_raddr = AW'(idx_q - CNT_W'(1));
					if (idx_q > p_q) begin
						pv_d = 1'b1;
						e_d = AW'(idx_q - CNT_W'(1));
						idx_d = idx_q - CNT_W'(1);
					end else begin
						pv_d = 1'b0;
						if (!pv_q)
							state_d = ffa_pkg::S_F_INS;
					end
				end else begin
					if (idx_q < count_q) begin
						pv_d = 1'b1;
						e_d = idx_q[AW-1:0];
						idx_d = idx_q + CNT_W'(1);
					end else begin
						pv_d = 1'b0;
						if (!pv_q) begin
							count_d = count_q - CNT_W'(1);
							state_d = ffa_pkg::S_FIN;
						end
					end
				end
			end
			ffa_pkg::S_F_INS: begin
				seg_we = 1'b1;
				seg_waddr = p_q[AW-1:0];
				seg_wdata = {bs_q, blen_q};
				count_d = count_q + CNT_W'(1);
				state_d = ffa_pkg::S_FIN;
			end
			ffa_pkg::S_FIN: begin
				done_d = 1'b1;
				status_d = st_q;
				data_offset_d = off_q;
				usage_bytes_d = usage_q;
				free_segments_d = count_q;
				state_d = ffa_pkg::S_IDLE;
			end
			default: begin
				state_d = ffa_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffa_pkg::S_INIT;
			arena_q <= LEN_W'(ffa_pkg::ARENA_BYTES);
			count_q <= CNT_W'(1);
			usage_q <= '0;
			valid_q <= '0;
			idx_q <= '0;
			pv_q <= 1'b0;
			done <= 1'b0;
		end else begin
			state_q <= state_d;
			arena_q <= arena_d;
			count_q <= count_d;
			usage_q <= usage_d;
			valid_q <= valid_d;
			idx_q <= idx_d;
			pv_q <= pv_d;
			done <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		st_q <= st_d;
		p_q <= p_d;
		size_q <= size_d;
		ksize_q <= ksize_d;
		blen_q <= blen_d;
		al_q <= al_d;
		foff_q <= foff_d;
		bs_q <= bs_d;
		off_q <= off_d;
		e_q <= e_d;
		slot_q <= slot_d;
		k_q <= k_d;
		mv_up_q <= mv_up_d;
		have_prev_q <= have_prev_d;
		has_next_q <= has_next_d;
		prev_start_q <= prev_start_d;
		prev_len_q <= prev_len_d;
		next_start_q <= next_start_d;
		next_len_q <= next_len_d;
		status <= status_d;
		data_offset <= data_offset_d;
		usage_bytes <= usage_bytes_d;
		free_segments <= free_segments_d;
	end

	always_ff @(posedge clk) begin
		if (seg_we)
			seg_mem[seg_waddr] <= seg_wdata;
		seg_rdata <= seg_mem[seg_raddr];
	end

	always_ff @(posedge clk) begin
		if (live_we)
			live_mem[live_waddr] <= live_wdata;
		live_rdata <= live_mem[idx_q[AW-1:0]];
	end

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for first_fit_free_list_allocator: directed and random
// allocate/free traffic, checked against an internal first-fit model of the arena.
// Depends on ffa_pkg and the allocator RTL.
`timescale 1ns / 100ps

typedef struct {
	ffa_pkg::status_t           st;
	logic [ffa_pkg::OFF_W-1:0]  off;
	logic [ffa_pkg::LEN_W-1:0]  usage;
	logic [ffa_pkg::CNT_W-1:0]  segs;
} alloc_result_t;

class arena_scoreboard;
	int seg_base [ffa_pkg::MAX_FREE];
	int seg_len  [ffa_pkg::MAX_FREE];
	int seg_cnt;
	bit live_on  [ffa_pkg::MAX_LIVE];
	int live_off [ffa_pkg::MAX_LIVE];
	int live_sz  [ffa_pkg::MAX_LIVE];
	int live_pad [ffa_pkg::MAX_LIVE];
	int usage_sum;
	alloc_result_t pending[$];
	int errors;
	int n_checked;
	int n_status [5];

	function new();
		errors = 0;
		n_checked = 0;
		foreach (n_status[i]) n_status[i] = 0;
		arena_init(ffa_pkg::ARENA_BYTES);
	endfunction

	function void arena_init(int bytes);
		foreach (live_on[i]) live_on[i] = 0;
		seg_base[0] = 0;
		seg_len[0] = bytes;
		seg_cnt = (bytes != 0) ? 1 : 0;
		usage_sum = 0;
	endfunction

	// register write: saturate then reinitialise
	function void set_arena(int value);
		int v;
		v = value & 32'h7fff;
		arena_init((v > ffa_pkg::ARENA_BYTES) ? ffa_pkg::ARENA_BYTES : v);
	endfunction

	function void drop_seg(int i);
		for (int j = i; j + 1 < seg_cnt; j++) begin
			seg_base[j] = seg_base[j + 1];
			seg_len[j] = seg_len[j + 1];
		end
		if (seg_cnt > 0) seg_cnt--;
	endfunction

	function ffa_pkg::status_t place(int size, int alog, output int off);
		int a, slot, data, aligned, pad, total, rest;
		off = 0;
		if (size == 0) return ffa_pkg::STAT_NOFIT;
		if (alog > ffa_pkg::MAX_ALIGN_LOG2) alog = ffa_pkg::MAX_ALIGN_LOG2;
		a = 1 << alog;
		slot = ffa_pkg::MAX_LIVE;
		for (int s = ffa_pkg::MAX_LIVE - 1; s >= 0; s--)
			if (!live_on[s]) slot = s;
		if (slot >= ffa_pkg::MAX_LIVE) return ffa_pkg::STAT_LIVEFULL;
		for (int i = 0; i < seg_cnt; i++) begin
			data = seg_base[i] + ffa_pkg::HEADER_BYTES;
			aligned = (data + a - 1) & ~(a - 1);
			pad = aligned - data;
			total = ffa_pkg::HEADER_BYTES + pad + size;
			if (seg_len[i] >= total) begin
				rest = seg_len[i] - total;
				if (rest > ffa_pkg::MIN_SPLIT_BYTES) begin
					seg_base[i] += total;
					seg_len[i] = rest;
				end else begin
					drop_seg(i);
				end
				live_on[slot] = 1;
				live_off[slot] = aligned;
				live_sz[slot] = size;
				live_pad[slot] = pad;
				usage_sum += size;
				off = aligned;
				return ffa_pkg::STAT_OK;
			end
		end
		return ffa_pkg::STAT_NOFIT;
	endfunction

	function ffa_pkg::status_t release_block(int off);
		int k, p, bs, len;
		bit mprev, mnext;
		k = ffa_pkg::MAX_LIVE;
		for (int s = ffa_pkg::MAX_LIVE - 1; s >= 0; s--)
			if (live_on[s] && live_off[s] == off) k = s;
		if (k >= ffa_pkg::MAX_LIVE) return ffa_pkg::STAT_UNKNOWN;
		bs = off - ffa_pkg::HEADER_BYTES - live_pad[k];
		len = ffa_pkg::HEADER_BYTES + live_pad[k] + live_sz[k];
		p = seg_cnt;
		for (int i = seg_cnt - 1; i >= 0; i--)
			if (seg_base[i] >= bs) p = i;
		mprev = (p > 0) && (seg_base[p - 1] + seg_len[p - 1] == bs);
		mnext = (p < seg_cnt) && (bs + len == seg_base[p]);
		if (mprev && mnext) begin
			seg_len[p - 1] += len + seg_len[p];
			drop_seg(p);
		end else if (mprev) begin
			seg_len[p - 1] += len;
		end else if (mnext) begin
			seg_base[p] = bs;
			seg_len[p] += len;
		end else begin
			if (seg_cnt >= ffa_pkg::MAX_FREE) return ffa_pkg::STAT_FREEFULL;
			for (int j = seg_cnt; j > p; j--) begin
				seg_base[j] = seg_base[j - 1];
				seg_len[j] = seg_len[j - 1];
			end
			seg_base[p] = bs;
			seg_len[p] = len;
			seg_cnt++;
		end
		usage_sum = (usage_sum >= live_sz[k]) ? usage_sum - live_sz[k] : 0;
		live_on[k] = 0;
		return ffa_pkg::STAT_OK;
	endfunction

	// note an accepted command and queue its expected result
	function void note_command(ffa_pkg::cmd_t c, int size, int alog, int foff);
		alloc_result_t r;
		int off;
		off = 0;
		if (c == ffa_pkg::CMD_ALLOC) r.st = place(size, alog, off);
		else r.st = release_block(foff);
		r.off = ffa_pkg::OFF_W'(off);
		r.usage = ffa_pkg::LEN_W'(usage_sum);
		r.segs = ffa_pkg::CNT_W'(seg_cnt);
		pending.push_back(r);
	endfunction

	task report(string what, int got, int want);
		$display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
		errors++;
	endtask

	task check_result(logic [2:0] st, logic [ffa_pkg::OFF_W-1:0] off,
			logic [ffa_pkg::LEN_W-1:0] usage, logic [ffa_pkg::CNT_W-1:0] segs);
		alloc_result_t r;
		if (pending.size() == 0) begin
			report("unexpected result status", int'(st), -1);
			return;
		end
		r = pending.pop_front();
		n_checked++;
		if (r.st <= ffa_pkg::STAT_LIVEFULL) n_status[r.st]++;
		if (st !== r.st) report("status", int'(st), int'(r.st));
		if (off !== r.off) report("data_offset", int'(off), int'(r.off));
		if (usage !== r.usage) report("usage_bytes", int'(usage), int'(r.usage));
		if (segs !== r.segs) report("free_segments", int'(segs), int'(r.segs));
	endtask

	function int live_count();
		int n;
		n = 0;
		foreach (live_on[i]) n += live_on[i];
		return n;
	endfunction

	function int some_live_offset();
		int idx[$];
		foreach (live_on[i]) if (live_on[i]) idx.push_back(i);
		if (idx.size() == 0) return -1;
		return live_off[idx[$urandom_range(0, idx.size() - 1)]];
	endfunction
endclass

module testbench;
	logic                      clk = 0;
	logic                      arst_n = 0;
	logic                      start = 0;
	logic                      busy;
	logic                      cmd = 0;
	logic [ffa_pkg::LEN_W-1:0] size_bytes = 0;
	logic [3:0]                align_log2 = 0;
	logic [ffa_pkg::OFF_W-1:0] free_offset = 0;
	logic                      wr_en = 0;
	logic [ffa_pkg::LEN_W-1:0] wr_data = 0;
	logic                      done;
	logic [2:0]                status;
	logic [ffa_pkg::OFF_W-1:0] data_offset;
	logic [ffa_pkg::LEN_W-1:0] usage_bytes;
	logic [ffa_pkg::CNT_W-1:0] free_segments;

	arena_scoreboard arena = new();
	int burst_left = 0;
	int n_sent = 0;

	first_fit_free_list_allocator DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.size_bytes(size_bytes), .align_log2(align_log2), .free_offset(free_offset),
		.wr_en(wr_en), .wr_data(wr_data), .done(done), .status(status),
		.data_offset(data_offset), .usage_bytes(usage_bytes), .free_segments(free_segments)
	);

	always #5 clk = ~clk;

	// a transfer takes place where start is high and busy low
	always @(posedge clk)
		if (arst_n && start && !busy)
			arena.note_command(ffa_pkg::cmd_t'(cmd), int'(size_bytes), int'(align_log2),
				int'(free_offset));

	always @(posedge clk)
		if (arst_n && done)
			arena.check_result(status, data_offset, usage_bytes, free_segments);

	initial begin
		#20_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// hold start until the transfer, then pause between bursts
	task send(ffa_pkg::cmd_t c, int size, int alog, int foff);
		start <= 1;
		cmd <= c;
		size_bytes <= ffa_pkg::LEN_W'(size);
		align_log2 <= 4'(alog);
		free_offset <= ffa_pkg::OFF_W'(foff);
		do @(posedge clk); while (busy);
		n_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			start <= 0;
			repeat ($urandom_range(1, 25)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
		end
	endtask

	task alloc(int size, int alog);
		send(ffa_pkg::CMD_ALLOC, size, alog, $urandom_range(0, 16383));
	endtask

	task release_at(int off);
		send(ffa_pkg::CMD_FREE, $urandom_range(0, 32767), $urandom_range(0, 15), off);
	endtask

	task write_arena(int value);
		start <= 0;
		@(posedge clk);
		while (arena.pending.size() != 0 || busy) @(posedge clk);
		wr_en <= 1;
		wr_data <= ffa_pkg::LEN_W'(value);
		@(posedge clk);
		wr_en <= 0;
		arena.set_arena(value);
		@(posedge clk);
	endtask

	task random_phase(int count);
		int off, r;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(0, 99);
			off = arena.some_live_offset();
			if (r < 40 && off >= 0) begin
				release_at(off);
			end else if (r < 45) begin
				release_at($urandom_range(0, 16383));
			end else if (r < 50) begin
				alloc($urandom_range(0, 32767), $urandom_range(0, 15));
			end else if (r < 58) begin
				alloc($urandom_range(1, 2048), $urandom_range(0, 15));
			end else begin
				alloc($urandom_range(1, 160), $urandom_range(0, 4));
			end
		end
	endtask

	initial begin
		int off;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: zero size, oversize, clamped alignment, frees, merges
		alloc(0, 0);
		alloc(16384, 0);
		alloc(32767, 15);
		alloc(1, 15);
		alloc(100, 0);
		alloc(37, 3);
		alloc(16, 12);
		release_at(16383);
		off = arena.some_live_offset();
		release_at(off);
		release_at(off);
		while ((off = arena.some_live_offset()) >= 0) release_at(off);
		write_arena(0);
		alloc(1, 0);
		release_at(0);
		write_arena(32767);
		// fill the live table to its limit
		while (arena.live_count() < ffa_pkg::MAX_LIVE) alloc(8, 0);
		alloc(8, 0);
		write_arena(256);
		alloc(200, 0);
		alloc(240, 0);
		alloc(1, 0);

		write_arena(ffa_pkg::ARENA_BYTES);
		random_phase(150);
		write_arena(4096);
		random_phase(130);
		write_arena(1024);
		random_phase(100);
		write_arena($urandom_range(300, 16384));
		random_phase(130);
		write_arena(ffa_pkg::ARENA_BYTES);
		random_phase(100);

		start <= 0;
		@(posedge clk);
		while (arena.pending.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		$display("Sent %0d commands, checked %0d results over several arena sizes.",
			n_sent, arena.n_checked);
		$display("Status tally ok/nofit/freefull/unknown/livefull: %0d/%0d/%0d/%0d/%0d",
			arena.n_status[0], arena.n_status[1], arena.n_status[2],
			arena.n_status[3], arena.n_status[4]);
		if (arena.errors == 0 && arena.pending.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
